// File: src/swmm_pkg.sv
// ----------------------------------------------------------------------------
// Sliding window min/max package
// Shared constants, transaction types and control structs for the window
// min/max cell chain.
// ----------------------------------------------------------------------------
`default_nettype none

package swmm_pkg;

   localparam int WINDOW_MAX = 64;
   localparam int DATA_W     = 32;
   localparam int CFG_W      = 7;
   localparam int IDX_W      = $clog2(WINDOW_MAX);
   localparam int LEN_W      = $clog2(WINDOW_MAX + 1);

   typedef struct packed {
      logic signed [DATA_W-1:0] sample;
      logic                     seq_start;
   } req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] win_min;
      logic signed [DATA_W-1:0] win_max;
   } rsp_type;

   // Partial extremes handed from a cell to its lower neighbor.
   typedef struct packed {
      logic                     valid;
      logic signed [DATA_W-1:0] min;
      logic signed [DATA_W-1:0] max;
   } part_type;

   typedef struct packed {
      logic shift;
      logic reduce;
   } cell_ctl_type;

   typedef enum logic [0:0] {
      ST_IDLE,
      ST_REDUCE
   } state_type;

endpackage

`default_nettype wire

// File: src/swmm_cell.sv
// ----------------------------------------------------------------------------
// Sliding window min/max cell
// Holds one window sample and its valid flag, and a partial minimum and
// maximum that is merged with the upper neighbor's partial on each reduce step.
// ----------------------------------------------------------------------------
`default_nettype none

module swmm_cell
   import swmm_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire cell_ctl_type             ctl,
   input  wire logic                     in_window,
   input  wire logic signed [DATA_W-1:0] left_value,
   input  wire logic                     left_valid,
   input  wire part_type                 right_part,
   output logic signed [DATA_W-1:0]      value,
   output logic                          valid,
   output part_type                      part
);

   logic signed [DATA_W-1:0] value_ff, value_in;
   logic                     valid_ff, valid_in;
   part_type                 part_ff, part_in;

   always_comb begin
      value_in = value_ff;
      valid_in = valid_ff;
      part_in  = part_ff;
      if (ctl.shift) begin
         // Samples that move past the window length are dropped here.
         value_in      = left_value;
         valid_in      = left_valid & in_window;
         part_in.valid = left_valid & in_window;
         part_in.min   = left_value;
         part_in.max   = left_value;
      end else if (ctl.reduce) begin
         part_in.valid = valid_ff | right_part.valid;
         if (!valid_ff) begin
            part_in.min = right_part.min;
            part_in.max = right_part.max;
         end else if (!right_part.valid) begin
            part_in.min = value_ff;
            part_in.max = value_ff;
         end else begin
            part_in.min = (right_part.min < value_ff) ? right_part.min : value_ff;
            part_in.max = (right_part.max > value_ff) ? right_part.max : value_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff      <= 1'b0;
         part_ff.valid <= 1'b0;
      end else begin
         valid_ff      <= valid_in;
         part_ff.valid <= part_in.valid;
      end
      value_ff    <= value_in;
      part_ff.min <= part_in.min;
      part_ff.max <= part_in.max;
   end

   assign value = value_ff;
   assign valid = valid_ff;
   assign part  = part_ff;

endmodule

`default_nettype wire

// File: src/sliding_window_min_max.sv
// ----------------------------------------------------------------------------
// Sliding window min/max
// Each accepted sample is shifted into cell 0; the partial min/max then travels
// one cell per cycle toward cell 0 across the window length L, held to 1..64,
// and the result is loaded into the output register. No new sample is taken
// until this is done, and the load waits while a held result awaits rsp_ready.
// Reset: window emptied, window_len = 1, idle; stored samples are not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module sliding_window_min_max
   import swmm_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire req_type          req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output rsp_type               rsp_data,
   input  wire logic             csr_wr_en,
   input  wire logic [CFG_W-1:0] csr_wr_data
);

   logic [CFG_W-1:0]         len_cfg_ff;
   logic [LEN_W-1:0]         len_eff;
   logic [IDX_W-1:0]         len_m1;

   state_type                state_ff, state_in;
   logic [IDX_W-1:0]         cnt_ff, cnt_in;
   cell_ctl_type             ctl;
   logic                     rsp_load;
   logic                     rsp_valid_ff, rsp_valid_in;
   rsp_type                  rsp_ff, rsp_in;

   logic signed [DATA_W-1:0] cell_value [WINDOW_MAX];
   logic [WINDOW_MAX-1:0]    valid_vec;
   part_type                 cell_part [WINDOW_MAX];

   always_ff @(posedge clock) begin
      if (reset) begin
         len_cfg_ff <= CFG_W'(1);
      end else if (csr_wr_en) begin
         len_cfg_ff <= csr_wr_data;
      end
   end

   always_comb begin
      if (len_cfg_ff == '0) begin
         len_eff = LEN_W'(1);
      end else if (32'(len_cfg_ff) > 32'(WINDOW_MAX)) begin
         len_eff = LEN_W'(WINDOW_MAX);
      end else begin
         len_eff = LEN_W'(len_cfg_ff);
      end
   end

   assign len_m1 = IDX_W'(len_eff - LEN_W'(1));

   genvar k;
   generate
      for (k = 0; k < WINDOW_MAX; k++) begin : g_cell
         logic signed [DATA_W-1:0] left_value;
         logic                     left_valid;
         part_type                 right_part;
         logic                     in_window;

         if (k == 0) begin : g_head
            assign left_value = req_data.sample;
            assign left_valid = 1'b1;
         end else begin : g_body
            // A sequence start empties the window behind the new sample.
            assign left_value = cell_value[k-1];
            assign left_valid = valid_vec[k-1] & ~req_data.seq_start;
         end

         if (k == WINDOW_MAX - 1) begin : g_tail
            assign right_part = '0;
         end else begin : g_link
            assign right_part = cell_part[k+1];
         end

         assign in_window = (LEN_W'(k) < len_eff);

         swmm_cell u_cell (
            .clock      (clock),
            .reset      (reset),
            .ctl        (ctl),
            .in_window  (in_window),
            .left_value (left_value),
            .left_valid (left_valid),
            .right_part (right_part),
            .value      (cell_value[k]),
            .valid      (valid_vec[k]),
            .part       (cell_part[k])
         );
      end
   endgenerate

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cnt_ff <= cnt_in;
      rsp_ff <= rsp_in;
   end

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      ctl       = '0;
      req_ready = 1'b0;
      rsp_load  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               ctl.shift = 1'b1;
               cnt_in    = len_m1;
               state_in  = ST_REDUCE;
            end
         end
         ST_REDUCE: begin
            if (cnt_ff != '0) begin
               ctl.reduce = 1'b1;
               cnt_in     = cnt_ff - IDX_W'(1);
            end else if (!valid_vec[len_m1]) begin
               // Window not yet full: this transaction gives no result.
               state_in = ST_IDLE;
            end else if (!rsp_valid_ff || rsp_ready) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_load | (rsp_valid_ff & ~rsp_ready);
      rsp_in       = rsp_ff;
      if (rsp_load) begin
         rsp_in.win_min = cell_part[0].min;
         rsp_in.win_max = cell_part[0].max;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Live samples always form a contiguous run starting at cell 0.
   a_valid_prefix : assert property (@(posedge clock) disable iff (reset)
      (valid_vec & (valid_vec + WINDOW_MAX'(1))) == '0)
      else $error("window valid flags are not a prefix");

   a_min_le_max : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_ff.win_min <= rsp_ff.win_max))
      else $error("result minimum exceeds maximum");

   a_load_after_reduce : assert property (@(posedge clock) disable iff (reset)
      rsp_load |-> (state_ff == ST_REDUCE && cnt_ff == '0 && valid_vec[len_m1]))
      else $error("result loaded before reduction finished");

   a_accept_starts : assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == ST_REDUCE && cnt_ff == $past(len_m1)))
      else $error("accepted transaction did not start a reduction");

endmodule

`default_nettype wire
